// ===== rtl/core/psc_pkg.sv =====
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types, signature patterns and codes for the payload signature
// classifier.
// ----------------------------------------------------------------------------
package psc_pkg;

	localparam int HIST_DEPTH = 12;
	localparam int SCAN_END   = 50;
	localparam int HDR_LEN    = 20;
	localparam int SHORT_LEN  = 7;
	localparam int LONG_LEN   = 12;

	localparam logic [7:0] AT_SIGN = 8'h40;

	localparam logic [31:0] SUBNET_LOW_RST  = 32'd3702856924;
	localparam logic [31:0] SUBNET_HIGH_RST = 32'd3702856942;

	// fixed header: 0C 00 00 00 01 01 00 00 06 00, then ten zero bytes
	localparam logic [7:0] HDR_PATTERN [HDR_LEN] = '{
		8'h0C, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00, 8'h00, 8'h06, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	localparam logic [7:0] SHORT_TEXT [SHORT_LEN] = '{
		8'h31, 8'h36, 8'h33, 8'h2E, 8'h63, 8'h6F, 8'h6D
	};

	localparam logic [7:0] LONG_TEXT [LONG_LEN] = '{
		8'h70, 8'h6F, 8'h70, 8'h6F, 8'h2E, 8'h31, 8'h36, 8'h33, 8'h2E, 8'h63, 8'h6F, 8'h6D
	};

	typedef enum logic {
		CFG_SUBNET_LOW  = 1'b0,
		CFG_SUBNET_HIGH = 1'b1
	} cfg_index_t;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_HEADER = 2'd1,
		KIND_RANGE  = 2'd2,
		KIND_DOMAIN = 2'd3
	} match_kind_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        last_byte;
		logic [15:0] payload_len;
		logic        is_tcp;
		logic [31:0] dest_addr;
		logic        peer_marked;
	} psc_item_t;

	typedef struct packed {
		logic        detected;
		match_kind_t kind;
	} psc_verdict_t;

endpackage

// ===== rtl/core/psc_match.sv =====
// ----------------------------------------------------------------------------
// psc_match
// Per-packet match state and verdict logic; consumes one byte per step.
// ----------------------------------------------------------------------------
module psc_match
	import psc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  psc_item_t    item,
	input  logic [31:0]  subnet_low,
	input  logic [31:0]  subnet_high,
	output psc_verdict_t verdict
);

	localparam logic [15:0] POS_MAX      = 16'hFFFF;
	localparam logic [15:0] LONG_MIN_POS = 16'(2 * LONG_LEN + 2);
	localparam logic [15:0] SHORT_MIN_POS = 16'(3 * SHORT_LEN);
	localparam logic [15:0] LONG_END_POS  = 16'(SCAN_END + LONG_LEN);
	localparam logic [15:0] SHORT_END_POS = 16'(SCAN_END + SHORT_LEN);

	logic [15:0] pos_q;
	logic [7:0]  recent_q [HIST_DEPTH];
	logic        hdr_ok_q;
	logic [31:0] len_word_q;
	logic        marker_zero_q;
	logic        domain_q;

	logic [7:0]  win [HIST_DEPTH + 1];
	logic        in_len;
	logic        hdr_ok_d;
	logic [31:0] len_word_d;
	logic        marker_zero_d;
	logic        domain_d;
	logic        long_hit;
	logic        short_hit;
	logic        in_subnet;

	always_comb begin
		win[0] = item.data_byte;
		for (int k = 1; k <= HIST_DEPTH; k++) begin
			win[k] = recent_q[k-1];
		end
	end

	always_comb begin
		in_len = pos_q < item.payload_len;

		long_hit = (pos_q >= LONG_MIN_POS) && (pos_q < LONG_END_POS) &&
			(win[LONG_LEN] == AT_SIGN);
		for (int i = 0; i < LONG_LEN; i++) begin
			if (win[LONG_LEN-1-i] != LONG_TEXT[i]) begin
				long_hit = 1'b0;
			end
		end

		short_hit = (pos_q >= SHORT_MIN_POS) && (pos_q < SHORT_END_POS) &&
			(({1'b0, pos_q} + 17'd2) <= {1'b0, item.payload_len}) &&
			(win[SHORT_LEN] == AT_SIGN);
		for (int i = 0; i < SHORT_LEN; i++) begin
			if (win[SHORT_LEN-1-i] != SHORT_TEXT[i]) begin
				short_hit = 1'b0;
			end
		end

		hdr_ok_d      = hdr_ok_q;
		len_word_d    = len_word_q;
		marker_zero_d = marker_zero_q;
		domain_d      = domain_q;
		if (in_len) begin
			if ((pos_q < 16'(HDR_LEN)) && (item.data_byte != HDR_PATTERN[pos_q[4:0]])) begin
				hdr_ok_d = 1'b0;
			end
			if (pos_q < 16'd4) begin
				case (pos_q[1:0])
					2'd0:    len_word_d[7:0]   = item.data_byte;
					2'd1:    len_word_d[15:8]  = item.data_byte;
					2'd2:    len_word_d[23:16] = item.data_byte;
					default: len_word_d[31:24] = item.data_byte;
				endcase
			end
			if (((pos_q == 16'd12) || (pos_q == 16'd13)) && (item.data_byte != 8'd0)) begin
				marker_zero_d = 1'b0;
			end
			if (long_hit || short_hit) begin
				domain_d = 1'b1;
			end
		end
	end

	// verdict from the state as it stands after this byte
	always_comb begin
		in_subnet = (item.dest_addr >= subnet_low) && (item.dest_addr <= subnet_high);
		verdict.detected = 1'b1;
		if (item.is_tcp && (item.payload_len == 16'(HDR_LEN)) && hdr_ok_d) begin
			verdict.kind = KIND_HEADER;
		end else if (item.is_tcp && item.peer_marked && in_subnet) begin
			verdict.kind = KIND_RANGE;
		end else if ((item.payload_len > 16'd13) && (len_word_d == {16'd0, item.payload_len}) &&
			marker_zero_d && domain_d) begin
			verdict.kind = KIND_DOMAIN;
		end else begin
			verdict.kind     = KIND_NONE;
			verdict.detected = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= '0;
			hdr_ok_q      <= 1'b1;
			len_word_q    <= '0;
			marker_zero_q <= 1'b1;
			domain_q      <= 1'b0;
			for (int k = 0; k < HIST_DEPTH; k++) begin
				recent_q[k] <= '0;
			end
		end else if (step) begin
			if (item.last_byte) begin
				// drop all packet state after the verdict
				pos_q         <= '0;
				hdr_ok_q      <= 1'b1;
				len_word_q    <= '0;
				marker_zero_q <= 1'b1;
				domain_q      <= 1'b0;
				for (int k = 0; k < HIST_DEPTH; k++) begin
					recent_q[k] <= '0;
				end
			end else begin
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + 16'd1;
				end
				hdr_ok_q      <= hdr_ok_d;
				len_word_q    <= len_word_d;
				marker_zero_q <= marker_zero_d;
				domain_q      <= domain_d;
				recent_q[0]   <= item.data_byte;
				for (int k = 1; k < HIST_DEPTH; k++) begin
					recent_q[k] <= recent_q[k-1];
				end
			end
		end
	end

endmodule

// ===== rtl/core/payload_signature_classifier_core.sv =====
// ----------------------------------------------------------------------------
// payload_signature_classifier_core
// Streams packet payload bytes and returns one verdict per packet.
// ----------------------------------------------------------------------------
// Takes one payload byte per transfer, with the packet's metadata alongside,
// and returns one verdict (detected, match_kind) on the transfer that follows
// the packet's last byte. A new byte is accepted every cycle while the input
// is not stalled; each byte passes through the input register while the match
// logic updates the packet state, and the verdict for the last byte lands in
// the output register. The input stalls only when a verdict is due while the
// previous verdict still waits in the output register. The subnet range
// registers must be written while no packet is in flight; a zero-length
// packet is one transfer with last_byte set.
// ----------------------------------------------------------------------------
module payload_signature_classifier_core
	import psc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [31:0] cfg_wdata,
	// byte input
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic [15:0] payload_len,
	input  logic        is_tcp,
	input  logic [31:0] dest_addr,
	input  logic        peer_marked,
	// verdict output
	output logic        out_valid,
	input  logic        out_stall,
	output logic        detected,
	output logic [1:0]  match_kind
);

	logic [31:0]  subnet_low_q;
	logic [31:0]  subnet_high_q;

	psc_item_t    item_s1;
	logic         valid_s1;
	logic         out_valid_q;
	psc_verdict_t verdict_q;
	psc_verdict_t verdict;

	logic         advance;
	logic         step;
	logic         in_xfer;

	// Configuration registers: plain writes, no read-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subnet_low_q  <= SUBNET_LOW_RST;
			subnet_high_q <= SUBNET_HIGH_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index_t'(cfg_index))
				CFG_SUBNET_LOW:  subnet_low_q  <= cfg_wdata;
				CFG_SUBNET_HIGH: subnet_high_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// A byte without a verdict always moves on; a last byte needs the
	// output register free or being emptied this cycle.
	assign advance  = !item_s1.last_byte || !out_valid_q || !out_stall;
	assign step     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign in_xfer  = in_valid && !in_stall;

	// Input register: hold while stalled, load on every transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1.data_byte   <= data_byte;
			item_s1.last_byte   <= last_byte;
			item_s1.payload_len <= payload_len;
			item_s1.is_tcp      <= is_tcp;
			item_s1.dest_addr   <= dest_addr;
			item_s1.peer_marked <= peer_marked;
		end
	end

	psc_match u_match (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.item        (item_s1),
		.subnet_low  (subnet_low_q),
		.subnet_high (subnet_high_q),
		.verdict     (verdict)
	);

	// Output register: load a verdict on the last byte, clear once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && item_s1.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && item_s1.last_byte) begin
			verdict_q <= verdict;
		end
	end

	assign out_valid  = out_valid_q;
	assign detected   = verdict_q.detected;
	assign match_kind = verdict_q.kind;

endmodule
